// ===== hw/rtl/sof_length_xor_frame_parser_defines.svh =====
// Assertion helpers used by the frame parser module.
// Each macro expects clk and rst_n in scope.
`ifndef SOF_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`define SOF_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, checked outside reset.
`define SLX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

// ===== hw/rtl/slx_pkg.sv =====
package slx_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOF_PRIMARY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOF_ALTERNATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_SOF_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd3;

    localparam logic [7:0] SOF_PRIMARY_RST   = 8'd254;
    localparam logic [7:0] SOF_ALTERNATE_RST = 8'd0;
    localparam logic       ALT_SOF_EN_RST    = 1'b1;
    localparam logic [7:0] MAX_PAYLOAD_RST   = 8'd128;

    // Body carries length byte and two command bytes ahead of the payload.
    localparam logic [7:0] BODY_EXTRA = 8'd3;
    // Longest length that keeps length + BODY_EXTRA within a byte.
    localparam logic [7:0] LEN_LIMIT  = 8'd252;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_FCS  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] sof_primary;
        logic [7:0] sof_alternate;
        logic       alt_sof_enable;
        logic [7:0] max_payload;
    } cfg_t;

endpackage

// ===== hw/rtl/slx_byte_if.sv =====
interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/slx_result_if.sv =====
interface slx_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] position;
    logic [7:0] value;
    logic       sof_kind;
    logic [7:0] frame_count;

    modport source (output valid, output kind, output position, output value,
                    output sof_kind, output frame_count, input ready);
    modport sink   (input valid, input kind, input position, input value,
                    input sof_kind, input frame_count, output ready);
endinterface

// ===== hw/rtl/slx_cfg_if.sv =====
interface slx_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sof_length_xor_frame_parser.sv =====
// A word that yields a result shows it in the cycle after it is accepted.
// Throughput: one word per cycle while the output is not stalled; the result register frees as it is taken.
// Rate is set by the single result register feeding the output channel.
// Reset (rst_n, async, low): hunt for a start byte, clear XOR/index/count,
// drop any pending result, load configuration reset values.
`include "sof_length_xor_frame_parser_defines.svh"

module sof_length_xor_frame_parser
    import slx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    slx_byte_if.sink     rx,
    slx_result_if.source result,
    slx_cfg_if.sink      cfg
);

    cfg_t regs;

    slx_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Frame tracking state.
    phase_t     phase_reg,       phase_next;
    logic [7:0] xor_reg,         xor_next;
    logic [7:0] byte_index_reg,  byte_index_next;
    logic [7:0] body_count_reg,  body_count_next;
    logic       start_kind_reg,  start_kind_next;

    // Result register.
    logic       out_valid_reg,   out_valid_next;
    kind_t      kind_reg,        kind_next;
    logic [7:0] position_reg,    position_next;
    logic [7:0] value_reg,       value_next;
    logic       sof_kind_reg,    sof_kind_next;
    logic [7:0] frame_count_reg, frame_count_next;

    logic       in_fire;
    logic       emit;
    kind_t      emit_kind;
    logic [7:0] emit_pos;
    logic [7:0] emit_fc;
    logic [7:0] index_inc;
    logic [7:0] b;

    // Take a word whenever the result register is empty or being drained.
    assign rx.ready  = !out_valid_reg || result.ready;
    assign in_fire   = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign index_inc = 8'(byte_index_reg + 8'd1);

    // Next frame state and the result caused by the incoming word.
    always_comb
    begin
        phase_next      = phase_reg;
        xor_next        = xor_reg;
        byte_index_next = byte_index_reg;
        body_count_next = body_count_reg;
        start_kind_next = start_kind_reg;
        emit            = 1'b0;
        emit_kind       = KIND_BYTE;
        emit_pos        = 8'd0;
        emit_fc         = 8'd0;

        case (phase_reg)
            PH_HUNT:
            begin
                // Primary wins when both start values match.
                if (b == regs.sof_primary)
                begin
                    start_kind_next = 1'b0;
                    phase_next      = PH_LEN;
                end
                else if (regs.alt_sof_enable && b == regs.sof_alternate)
                begin
                    start_kind_next = 1'b1;
                    phase_next      = PH_LEN;
                end
            end
            PH_LEN:
            begin
                emit = 1'b1;
                if (b > regs.max_payload || b > LEN_LIMIT)
                begin
                    // Oversized length: report and go back to hunting.
                    phase_next = PH_HUNT;
                    emit_kind  = KIND_REJECT;
                end
                else
                begin
                    xor_next        = b;
                    byte_index_next = 8'd1;
                    body_count_next = 8'(b + BODY_EXTRA);
                    phase_next      = PH_BODY;
                    emit_fc         = 8'(b + BODY_EXTRA);
                end
            end
            PH_BODY:
            begin
                emit            = 1'b1;
                xor_next        = xor_reg ^ b;
                emit_pos        = byte_index_reg;
                emit_fc         = body_count_reg;
                byte_index_next = index_inc;
                if (index_inc == body_count_reg)
                begin
                    phase_next = PH_FCS;
                end
            end
            PH_FCS:
            begin
                // Check byte against the running XOR of the body.
                emit       = 1'b1;
                phase_next = PH_HUNT;
                emit_kind  = (b == xor_reg) ? KIND_GOOD : KIND_BAD;
                emit_pos   = body_count_reg;
                emit_fc    = body_count_reg;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Load, hold or drain the result register.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        position_next    = position_reg;
        value_next       = value_reg;
        sof_kind_next    = sof_kind_reg;
        frame_count_next = frame_count_reg;

        if (in_fire && emit)
        begin
            out_valid_next   = 1'b1;
            kind_next        = emit_kind;
            position_next    = emit_pos;
            value_next       = b;
            sof_kind_next    = start_kind_reg;
            frame_count_next = emit_fc;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            xor_reg        <= 8'd0;
            byte_index_reg <= 8'd0;
            body_count_reg <= 8'd0;
            start_kind_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                xor_reg        <= xor_next;
                byte_index_reg <= byte_index_next;
                body_count_reg <= body_count_next;
                start_kind_reg <= start_kind_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        position_reg    <= position_next;
        value_reg       <= value_next;
        sof_kind_reg    <= sof_kind_next;
        frame_count_reg <= frame_count_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.position    = position_reg;
    assign result.value       = value_reg;
    assign result.sof_kind    = sof_kind_reg;
    assign result.frame_count = frame_count_reg;

    // A word is never taken while a stalled result would be overwritten.
    `SLX_ASSERT_NOW(a_no_overwrite, in_fire, !out_valid_reg || result.ready)
    // Inside the body the next index is always short of the body length.
    `SLX_ASSERT_NOW(a_body_index, phase_reg == PH_BODY, byte_index_reg < body_count_reg)
    // A rejection carries zero position and zero body length.
    `SLX_ASSERT_NOW(a_reject_zero, out_valid_reg && kind_reg == KIND_REJECT,
                    position_reg == 8'd0 && frame_count_reg == 8'd0)
    // The check byte always ends the frame.
    `SLX_ASSERT_NEXT(a_fcs_ends, in_fire && phase_reg == PH_FCS, phase_reg == PH_HUNT)

endmodule

// ===== hw/rtl/slx_cfg_regs.sv =====
module slx_cfg_regs
    import slx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    slx_cfg_if.sink    cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SOF_PRIMARY:   regs_next.sof_primary    = cfg.data;
                REG_SOF_ALTERNATE: regs_next.sof_alternate  = cfg.data;
                REG_ALT_SOF_EN:    regs_next.alt_sof_enable = cfg.data[0];
                REG_MAX_PAYLOAD:   regs_next.max_payload    = cfg.data;
                default:           regs_next = regs_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.sof_primary    <= SOF_PRIMARY_RST;
            regs_reg.sof_alternate  <= SOF_ALTERNATE_RST;
            regs_reg.alt_sof_enable <= ALT_SOF_EN_RST;
            regs_reg.max_payload    <= MAX_PAYLOAD_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import slx_pkg::*;

    // Give up on a run that has stalled: this is many times the slowest legal run.
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    // How long to wait once nothing is expected, so that a word still
    // in flight can show up. The block answers on the cycle after it accepts.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_WORDS  = 2000;
    localparam int unsigned RECONFIG_SPAN = 400;

    // One output word as it should leave the block.
    typedef struct {
        kind_t      kind;
        logic [7:0] position;
        logic [7:0] value;
        logic       sof_kind;
        logic [7:0] frame_count;
    } frame_word_t;

    logic clk;
    logic rst_n;

    slx_byte_if   byte_ch ();
    slx_result_if result_ch ();
    slx_cfg_if    cfg_ch ();

    sof_length_xor_frame_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (byte_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Our own copy of the register file and of the deframer state.
    cfg_t        regs_model;
    phase_t      parse_phase;
    logic [7:0]  xor_acc;
    logic [7:0]  next_index;
    logic [7:0]  body_len;
    logic        frame_alt;

    // Output words that the deframer owes us, oldest first.
    frame_word_t words_due[$];
    int unsigned words_predicted;
    int unsigned mismatches;

    // Idling controls for the stimulus and the receiver.
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned rx_hold_request;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap length: mostly short, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void expect_word(kind_t k, logic [7:0] pos, logic [7:0] val,
                                        logic [7:0] count);
        frame_word_t w;
        w.kind        = k;
        w.position    = pos;
        w.value       = val;
        w.sof_kind    = frame_alt;
        w.frame_count = count;
        words_due.push_back(w);
        words_predicted++;
    endfunction

    // Advance the deframer copy by one received byte and queue what it owes.
    function automatic void parse_byte(logic [7:0] b);
        case (parse_phase)
            PH_HUNT:
            begin
                // The primary start byte wins when both values match.
                if (b == regs_model.sof_primary)
                begin
                    frame_alt   = 1'b0;
                    parse_phase = PH_LEN;
                end
                else if (regs_model.alt_sof_enable && b == regs_model.sof_alternate)
                begin
                    frame_alt   = 1'b1;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                // Reject lengths past the register, and past the hard limit
                // that keeps length plus the command bytes within a byte.
                if (b > regs_model.max_payload || b > LEN_LIMIT)
                begin
                    parse_phase = PH_HUNT;
                    expect_word(KIND_REJECT, 8'd0, b, 8'd0);
                end
                else
                begin
                    xor_acc     = b;
                    next_index  = 8'd1;
                    body_len    = b + BODY_EXTRA;
                    parse_phase = PH_BODY;
                    expect_word(KIND_BYTE, 8'd0, b, body_len);
                end
            end
            PH_BODY:
            begin
                xor_acc = xor_acc ^ b;
                expect_word(KIND_BYTE, next_index, b, body_len);
                next_index = next_index + 8'd1;
                if (next_index == body_len)
                    parse_phase = PH_FCS;
            end
            default:
            begin
                parse_phase = PH_HUNT;
                expect_word((b == xor_acc) ? KIND_GOOD : KIND_BAD, body_len, b, body_len);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every word the block hands over with the oldest one it owes.
    always @(posedge clk)
    begin
        frame_word_t w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (words_due.size() == 0)
            begin
                $error("unexpected word: kind %0d position %0d value %0d",
                       result_ch.kind, result_ch.position, result_ch.value);
                mismatches++;
            end
            else
            begin
                w = words_due.pop_front();
                check_field("kind", 8'(w.kind), 8'(result_ch.kind));
                check_field("position", w.position, result_ch.position);
                check_field("value", w.value, result_ch.value);
                check_field("sof_kind", 8'(w.sof_kind), 8'(result_ch.sof_kind));
                check_field("frame_count", w.frame_count, result_ch.frame_count);
            end
        end
    end

    // Receiver: drop ready for random stretches, or for one long hold-off
    // when a test asks for it. The hold-off is counted here.
    initial
    begin
        int unsigned stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                stall_left      = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench failed");
        $finish;
    end

    // Drop valid and hold the byte channel quiet for the given idle length.
    task automatic tx_idle(input int unsigned n);
        byte_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Offer one byte until it is taken. Valid stays high afterward so that
    // back-to-back bytes need no second assignment in one step.
    task automatic send_byte(input logic [7:0] b);
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        parse_byte(b);
        @(negedge clk);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
            tx_idle(gap_len());
    endtask

    // Pause the sender until every owed word is in, then let the pipe settle.
    task automatic drain_words;
        byte_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register. Valid is left high; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_SOF_PRIMARY:   regs_model.sof_primary    = data;
            REG_SOF_ALTERNATE: regs_model.sof_alternate  = data;
            REG_ALT_SOF_EN:    regs_model.alt_sof_enable = data[0];
            REG_MAX_PAYLOAD:   regs_model.max_payload    = data;
            default:           ;
        endcase
        @(negedge clk);
    endtask

    // Only call with the block idle (after drain_words).
    task automatic load_config(input logic [7:0] primary, input logic [7:0] alternate,
                               input logic alt_en, input logic [7:0] max_len);
        write_reg(REG_SOF_PRIMARY, primary);
        write_reg(REG_SOF_ALTERNATE, alternate);
        write_reg(REG_ALT_SOF_EN, {7'd0, alt_en});
        write_reg(REG_MAX_PAYLOAD, max_len);
        cfg_ch.valid <= 1'b0;
    endtask

    // Send a whole frame with random command and payload bytes. The check
    // byte is the running XOR, or a corrupted copy of it.
    task automatic send_frame(input bit alt, input bit corrupt, input logic [7:0] len);
        logic [7:0] x;
        logic [7:0] b;
        send_byte(alt ? regs_model.sof_alternate : regs_model.sof_primary);
        send_byte(len);
        x = len;
        for (int i = 0; i < int'(len) + 2; i++)
        begin
            b = 8'($urandom);
            x = x ^ b;
            send_byte(b);
        end
        send_byte(corrupt ? x ^ 8'($urandom_range(1, 255)) : x);
    endtask

    function automatic logic [7:0] length_cap();
        return (regs_model.max_payload > LEN_LIMIT) ? LEN_LIMIT : regs_model.max_payload;
    endfunction

    // Mostly short frames; once in a while anything up to the cap.
    function automatic logic [7:0] pick_length();
        logic [7:0] cap;
        cap = length_cap();
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom_range(0, cap));
        return 8'($urandom_range(0, (cap < 12) ? cap : 12));
    endfunction

    // Reset configuration: a good check on the primary start byte, a bad one on the alternate,
    // lengths past the register and past the hard limit, and a hunting byte.
    task automatic test_directed_frames;
        send_byte(8'h55);
        send_byte(SOF_PRIMARY_RST);
        send_byte(8'd0);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(SOF_ALTERNATE_RST);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(SOF_PRIMARY_RST);
        send_byte(8'hFF);
        send_byte(SOF_PRIMARY_RST);
        send_byte(LEN_LIMIT + 8'd1);
        send_byte(SOF_PRIMARY_RST);
        send_byte(MAX_PAYLOAD_RST + 8'd1);
        send_byte(SOF_PRIMARY_RST);
        send_byte(8'd2);
        repeat (4) send_byte(8'hFF);
        send_byte(8'h02);
        drain_words();
    endtask

    // Walk the registers through their extremes.
    task automatic test_config_extremes;
        // Zero max length: only empty payloads pass.
        load_config(8'h00, 8'hFF, 1'b1, 8'd0);
        send_frame(1'b0, 1'b0, 8'd0);
        send_frame(1'b1, 1'b1, 8'd0);
        send_byte(8'h00);
        send_byte(8'd1);
        send_byte(8'hFF);
        send_byte(8'd253);
        drain_words();

        // Alternate disabled: its value is ignored while hunting. Longest frame.
        load_config(8'hFF, 8'h00, 1'b0, LEN_LIMIT);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(1'b0, 1'b0, LEN_LIMIT);
        send_byte(8'hFF);
        send_byte(LEN_LIMIT + 8'd1);
        drain_words();

        // Both start values equal: the frame counts as primary.
        load_config(8'h7E, 8'h7E, 1'b1, 8'd5);
        send_frame(1'b0, 1'b0, 8'd5);
        send_frame(1'b1, 1'b1, 8'd3);
        send_byte(8'h7E);
        send_byte(8'd6);
        drain_words();
    endtask

    // Writes to indexes past the last register must not disturb anything.
    task automatic test_unknown_registers;
        load_config(8'hA5, 8'h5A, 1'b1, 8'd16);
        // Let the dropped valid land before the next write raises it again.
        @(negedge clk);
        for (int i = int'(REG_MAX_PAYLOAD) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 8'($urandom));
        cfg_ch.valid <= 1'b0;
        send_frame(1'b0, 1'b0, 8'd16);
        send_frame(1'b1, 1'b0, 8'd2);
        send_byte(8'd17);
        drain_words();
    endtask

    // Hold the receiver off while the sender keeps offering, so the block
    // fills and stalls its input.
    task automatic test_output_backpressure;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        load_config(SOF_PRIMARY_RST, SOF_ALTERNATE_RST, 1'b1, MAX_PAYLOAD_RST);
        rx_hold_request = 300;
        send_frame(1'b0, 1'b0, 8'd20);
        send_frame(1'b1, 1'b1, 8'd12);
        send_frame(1'b0, 1'b0, 8'd0);
        drain_words();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, plus bad checks,
    // oversize lengths, truncated frames and line noise.
    task automatic test_random_traffic;
        int unsigned first;
        int unsigned next_reconfig;
        int unsigned r;
        logic [7:0]  len;
        int unsigned cut;
        first         = words_predicted;
        next_reconfig = first;
        while (words_predicted - first < RANDOM_WORDS)
        begin
            if (words_predicted >= next_reconfig)
            begin
                drain_words();
                case ($urandom_range(0, 3))
                    0:       len = 8'd0;
                    1:       len = LEN_LIMIT;
                    default: len = 8'($urandom_range(0, LEN_LIMIT));
                endcase
                load_config(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), len);
                // Some spans run with no idling at all on either side.
                tx_gaps_on    = $urandom_range(0, 2) != 0;
                rx_stalls_on  = $urandom_range(0, 2) != 0;
                next_reconfig = words_predicted + RECONFIG_SPAN;
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(1'($urandom_range(0, 1)), 1'b0, pick_length());
            else if (r < 80)
                send_frame(1'($urandom_range(0, 1)), 1'b1, pick_length());
            else if (r < 85)
            begin
                send_byte($urandom_range(0, 1) ? regs_model.sof_alternate
                                               : regs_model.sof_primary);
                send_byte(8'($urandom_range(int'(length_cap()) + 1, 255)));
            end
            else if (r < 90)
            begin
                // Send at most the body, never the check byte; the next frame lands inside this one.
                len = pick_length();
                send_byte(regs_model.sof_primary);
                send_byte(len);
                cut = $urandom_range(0, int'(len) + 2);
                repeat (cut) send_byte(8'($urandom));
            end
            else
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            if ($urandom_range(0, 49) == 0)
                drain_words();
        end
        drain_words();
    endtask

    initial
    begin
        // Drive every input to a known value from time zero and hold reset.
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = 8'd0;
        tx_gaps_on      = 1'b1;
        rx_stalls_on    = 1'b1;
        rx_hold_request = 0;
        mismatches      = 0;
        words_predicted = 0;
        regs_model.sof_primary    = SOF_PRIMARY_RST;
        regs_model.sof_alternate  = SOF_ALTERNATE_RST;
        regs_model.alt_sof_enable = ALT_SOF_EN_RST;
        regs_model.max_payload    = MAX_PAYLOAD_RST;
        parse_phase = PH_HUNT;
        xor_acc     = 8'd0;
        next_index  = 8'd0;
        body_len    = 8'd0;
        frame_alt   = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_config_extremes();
        test_unknown_registers();
        test_output_backpressure();
        test_random_traffic();

        drain_words();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sof_length_xor_frame_parser.f =====
+incdir+hw/rtl
hw/rtl/slx_pkg.sv
hw/rtl/slx_byte_if.sv
hw/rtl/slx_result_if.sv
hw/rtl/slx_cfg_if.sv
hw/rtl/slx_cfg_regs.sv
hw/rtl/sof_length_xor_frame_parser.sv
sim/testbench.sv
